@@ src/vgs_pkg.sv @@
// Shared types, codes and saturating helpers for the velocity goal supervisor.
`default_nettype none

package vgs_pkg;

  // Axis count and default widths
  localparam int AXES          = 6;
  localparam int VEL_BITS_DEF  = 24;
  localparam int TIME_BITS_DEF = 48;

  // Multiplier operand layout: a 64-bit time magnitude cut into two halves
  localparam int MAG_W  = 64;
  localparam int HALF_W = 32;
  localparam int OUT_W  = 64;

  // Request opcodes
  localparam int            OP_W     = 3;
  localparam logic [OP_W-1:0] OP_GOAL  = 3'd0;
  localparam logic [OP_W-1:0] OP_MEAS  = 3'd1;
  localparam logic [OP_W-1:0] OP_MODE  = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

  // Kinds of request carried down the pipeline
  localparam int              KIND_W  = 2;
  localparam logic [KIND_W-1:0] K_GOAL  = 2'd0;
  localparam logic [KIND_W-1:0] K_MODE  = 2'd1;
  localparam logic [KIND_W-1:0] K_QUERY = 2'd2;
  localparam logic [KIND_W-1:0] K_TICK  = 2'd3;

  // Result kinds
  localparam logic RES_VELOCITY = 1'b0;
  localparam logic RES_DISTANCE = 1'b1;

  // Signed 64-bit limits
  localparam logic [OUT_W-1:0] MAG63     = 64'h8000_0000_0000_0000;
  localparam logic [OUT_W-1:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [OUT_W-1:0] INT64_MIN = 64'h8000_0000_0000_0000;

  // Control decoded at acceptance, carried with the request
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              integ;
    logic              time_reached;
  } front_ctl_t;

  // Stage loads and retirement control broadcast to every lane
  typedef struct packed {
    logic              s1_ld;
    logic              s2_ld;
    logic              s3_ld;
    logic              retire;
    logic [KIND_W-1:0] kind;
    logic              integ;
    logic              active;
  } lane_ctl_t;

  // Saturating signed 64-bit add
  function automatic logic [OUT_W-1:0] sat_add(input logic [OUT_W-1:0] a,
                                               input logic [OUT_W-1:0] b);
    logic [OUT_W:0] s;
    s = {a[OUT_W-1], a} + {b[OUT_W-1], b};
    if (s[OUT_W] != s[OUT_W-1]) begin
      return s[OUT_W] ? INT64_MIN : INT64_MAX;
    end
    return s[OUT_W-1:0];
  endfunction

  // Saturating signed 64-bit subtract
  function automatic logic [OUT_W-1:0] sat_sub(input logic [OUT_W-1:0] a,
                                               input logic [OUT_W-1:0] b);
    logic [OUT_W:0] s;
    s = {a[OUT_W-1], a} - {b[OUT_W-1], b};
    if (s[OUT_W] != s[OUT_W-1]) begin
      return s[OUT_W] ? INT64_MIN : INT64_MAX;
    end
    return s[OUT_W-1:0];
  endfunction

  // Unsigned magnitude of a signed 64-bit word
  function automatic logic [OUT_W-1:0] mag64(input logic [OUT_W-1:0] x);
    return x[OUT_W-1] ? (~x + 64'd1) : x;
  endfunction

endpackage

`default_nettype wire

@@ src/vgs_front.sv @@
// Front end: request decode, early supervisor state and multiplier operand select.
`default_nettype none

module vgs_front
  import vgs_pkg::*;
#(
  parameter int VELOCITY_BITS = VEL_BITS_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [OP_W-1:0]                     opcode,
  input  logic [AXES-1:0][VELOCITY_BITS-1:0]  vel,
  input  logic [31:0]                         goal_duration,
  input  logic                                integrate_flag,
  input  logic                                velocity_mode,
  input  logic [TIME_BITS-1:0]                now_time,
  output logic                                push,
  output front_ctl_t                          ctl,
  output logic [MAG_W-1:0]                    mb,
  output logic                                neg_b,
  output logic [AXES-1:0][VELOCITY_BITS-1:0]  lane_a
);

  logic                               enabled_r;
  logic [TIME_BITS-1:0]               last_tick_r;
  logic [TIME_BITS-1:0]               goal_start_r;
  logic [31:0]                        time_len_r;
  logic                               integ_r;
  logic [AXES-1:0][VELOCITY_BITS-1:0] meas_r;
  logic [AXES-1:0][VELOCITY_BITS-1:0] gvel_r;

  logic [TIME_BITS-1:0] tl_ext;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] ahead;
  logic                 late;
  logic [MAG_W:0]       ahead_sum;

  // Time differences against the goal start
  assign tl_ext    = TIME_BITS'(time_len_r);
  assign elapsed   = now_time - goal_start_r;
  assign ahead     = goal_start_r - now_time;
  assign late      = now_time >= goal_start_r;
  assign ahead_sum = {1'b0, MAG_W'(time_len_r)} + {1'b0, MAG_W'(ahead)};

  // Decode the request and pick the multiplier operands
  always_comb begin
    push   = 1'b0;
    ctl    = '0;
    mb     = '0;
    neg_b  = 1'b0;
    lane_a = '0;
    case (opcode)
      OP_GOAL: begin
        push     = 1'b1;
        ctl.kind = K_GOAL;
        mb       = MAG_W'(goal_duration);
        lane_a   = vel;
      end
      OP_MODE: begin
        push     = velocity_mode != enabled_r;
        ctl.kind = K_MODE;
      end
      OP_QUERY: begin
        push      = 1'b1;
        ctl.kind  = K_QUERY;
        ctl.integ = integ_r;
        lane_a    = gvel_r;
        if (!integ_r) begin
          if (late) begin
            if (tl_ext >= elapsed) begin
              mb = MAG_W'(tl_ext - elapsed);
            end else begin
              mb    = MAG_W'(elapsed - tl_ext);
              neg_b = 1'b1;
            end
          end else begin
            mb = ahead_sum[MAG_W] ? '1 : ahead_sum[MAG_W-1:0];
          end
        end
      end
      OP_TICK: begin
        push             = enabled_r;
        ctl.kind         = K_TICK;
        ctl.integ        = integ_r;
        ctl.time_reached = late && (elapsed >= tl_ext);
        lane_a           = meas_r;
        if (now_time > last_tick_r) begin
          mb = MAG_W'(now_time - last_tick_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Update the early state as each request is accepted
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      last_tick_r  <= '0;
      goal_start_r <= '0;
      time_len_r   <= '0;
      integ_r      <= 1'b0;
      meas_r       <= '0;
      gvel_r       <= '0;
    end else if (accept) begin
      case (opcode)
        OP_GOAL: begin
          gvel_r       <= vel;
          time_len_r   <= goal_duration;
          integ_r      <= integrate_flag;
          goal_start_r <= now_time;
          last_tick_r  <= now_time;
        end
        OP_MEAS: begin
          meas_r <= vel;
        end
        OP_MODE: begin
          if (velocity_mode != enabled_r) begin
            gvel_r <= '0;
          end
          enabled_r <= velocity_mode;
        end
        OP_TICK: begin
          if (enabled_r) begin
            last_tick_r <= now_time;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/vgs_lane.sv @@
// One axis lane: pipelined saturating multiply, travel integrator and target store.
`default_nettype none

module vgs_lane
  import vgs_pkg::*;
#(
  parameter int VELOCITY_BITS = VEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  lane_ctl_t                       ctl,
  input  logic signed [VELOCITY_BITS-1:0] a_in,
  input  logic                            neg_b_in,
  input  logic [MAG_W-1:0]                s1_mb,
  output logic [OUT_W-1:0]                value,
  output logic                            reach
);

  localparam int PPW = VELOCITY_BITS + HALF_W;
  localparam int PW  = VELOCITY_BITS + MAG_W;

  logic [VELOCITY_BITS-1:0] a_bits;
  logic [VELOCITY_BITS-1:0] a_mag;

  logic [VELOCITY_BITS-1:0] s1_ma_r;
  logic                     s1_neg_r;
  logic [VELOCITY_BITS-1:0] s1_a_r;

  logic [PPW-1:0]           s2_lo_r;
  logic [PPW-1:0]           s2_hi_r;
  logic                     s2_neg_r;
  logic [VELOCITY_BITS-1:0] s2_a_r;

  logic [PW-1:0]            prod_full;
  logic [PW-1:0]            prod_lim;
  logic [OUT_W-1:0]         prod_sat;
  logic [OUT_W-1:0]         s3_prod_r;
  logic [VELOCITY_BITS-1:0] s3_a_r;

  logic [OUT_W-1:0]         trav_r;
  logic [OUT_W-1:0]         target_r;
  logic signed [VELOCITY_BITS-1:0] gvel_r;
  logic [OUT_W-1:0]         trav_sum;

  // Split the velocity into sign and magnitude
  assign a_bits = a_in;
  assign a_mag  = a_bits[VELOCITY_BITS-1] ? (~a_bits + VELOCITY_BITS'(1)) : a_bits;

  // Stage 1: hold magnitude, product sign and raw velocity
  always_ff @(posedge clk) begin
    if (ctl.s1_ld) begin
      s1_ma_r  <= a_mag;
      s1_neg_r <= a_bits[VELOCITY_BITS-1] ^ neg_b_in;
      s1_a_r   <= a_bits;
    end
  end

  // Stage 2: two partial products against the halves of the time magnitude
  always_ff @(posedge clk) begin
    if (ctl.s2_ld) begin
      s2_lo_r  <= PPW'(s1_ma_r) * PPW'(s1_mb[HALF_W-1:0]);
      s2_hi_r  <= PPW'(s1_ma_r) * PPW'(s1_mb[MAG_W-1:HALF_W]);
      s2_neg_r <= s1_neg_r;
      s2_a_r   <= s1_a_r;
    end
  end

  // Stage 3: combine partial products and saturate to the signed range
  assign prod_full = (PW'(s2_hi_r) << HALF_W) + PW'(s2_lo_r);
  assign prod_lim  = s2_neg_r ? PW'(MAG63) : PW'(MAG63 - 64'd1);

  always_comb begin
    if (prod_full > prod_lim) begin
      prod_sat = s2_neg_r ? INT64_MIN : INT64_MAX;
    end else if (s2_neg_r) begin
      prod_sat = ~prod_full[OUT_W-1:0] + 64'd1;
    end else begin
      prod_sat = prod_full[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s3_ld) begin
      s3_prod_r <= prod_sat;
      s3_a_r    <= s2_a_r;
    end
  end

  // Final stage: integrate travel and check it against the target
  assign trav_sum = sat_add(trav_r, s3_prod_r);
  assign reach    = (target_r != '0) && (mag64(trav_sum) >= mag64(target_r));

  always_comb begin
    case (ctl.kind)
      K_TICK:  value = OUT_W'(gvel_r);
      K_QUERY: value = ctl.integ ? sat_sub(target_r, trav_r) : s3_prod_r;
      default: value = '0;
    endcase
  end

  // Retire: store a new goal or advance the integrator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trav_r   <= '0;
      target_r <= '0;
      gvel_r   <= '0;
    end else if (ctl.retire) begin
      if (ctl.kind == K_GOAL) begin
        trav_r   <= '0;
        target_r <= s3_prod_r;
        gvel_r   <= s3_a_r;
      end else if (ctl.kind == K_TICK && ctl.active) begin
        trav_r <= trav_sum;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/vgs_merge.sv @@
// Merge stage: combine lane reach flags and lane values into one result.
`default_nettype none

module vgs_merge
  import vgs_pkg::*;
(
  input  logic [KIND_W-1:0]          kind,
  input  logic                       active,
  input  logic                       integ,
  input  logic                       time_reached,
  input  logic [AXES-1:0]            reach,
  input  logic [AXES-1:0][OUT_W-1:0] lane_val,
  output logic                       reached,
  output logic                       res_kind,
  output logic [AXES-1:0][OUT_W-1:0] res_val
);

  // Reach on any axis in integrate mode, otherwise on elapsed time
  assign reached  = active && (integ ? (|reach) : time_reached);
  assign res_kind = (kind == K_QUERY) ? RES_DISTANCE : RES_VELOCITY;

  // Zero the answer when there is no goal, or the tick ends it
  always_comb begin
    case (kind)
      K_TICK:  res_val = (!active || reached) ? '0 : lane_val;
      K_QUERY: res_val = active ? lane_val : '0;
      default: res_val = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/velocity_goal_supervisor.sv @@
// Top level: six-axis velocity goal supervisor with lane pipeline and output register.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+---------------------------------------------
//   input    | in  | in_valid / in_stall  | in_opcode, in_lin_x..in_ang_z, in_goal_duration,
//            |     |                      | in_integrate_flag, in_velocity_mode, in_now_time
//   result   | out | out_valid / out_stall| out_result_kind, out_lin_x..out_ang_z
//
// One request per cycle sustained while out_stall is low; a query or tick result passes
// through the per-lane multiply pipeline: operand register, two 32-bit partial products,
// then combine and saturate, ahead of the output register.
// Reset (rst_n low, synchronous) clears the pipeline, goal and mode state.
// out_stall holds the output register; stages with bubbles keep accepting requests.
`default_nettype none

module velocity_goal_supervisor
  import vgs_pkg::*;
#(
  parameter int VELOCITY_BITS = VEL_BITS_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [OP_W-1:0]                 in_opcode,
  input  logic signed [VELOCITY_BITS-1:0] in_lin_x,
  input  logic signed [VELOCITY_BITS-1:0] in_lin_y,
  input  logic signed [VELOCITY_BITS-1:0] in_lin_z,
  input  logic signed [VELOCITY_BITS-1:0] in_ang_x,
  input  logic signed [VELOCITY_BITS-1:0] in_ang_y,
  input  logic signed [VELOCITY_BITS-1:0] in_ang_z,
  input  logic [31:0]                     in_goal_duration,
  input  logic                            in_integrate_flag,
  input  logic                            in_velocity_mode,
  input  logic [TIME_BITS-1:0]            in_now_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_result_kind,
  output logic signed [OUT_W-1:0]         out_lin_x,
  output logic signed [OUT_W-1:0]         out_lin_y,
  output logic signed [OUT_W-1:0]         out_lin_z,
  output logic signed [OUT_W-1:0]         out_ang_x,
  output logic signed [OUT_W-1:0]         out_ang_y,
  output logic signed [OUT_W-1:0]         out_ang_z
);

  logic [AXES-1:0][VELOCITY_BITS-1:0] in_vel;
  logic                               accept;
  logic                               push;
  front_ctl_t                         front_ctl;
  logic [MAG_W-1:0]                   front_mb;
  logic                               front_neg_b;
  logic [AXES-1:0][VELOCITY_BITS-1:0] lane_a;

  logic             s1_valid_r, s2_valid_r, s3_valid_r;
  front_ctl_t       s1_ctl_r, s2_ctl_r, s3_ctl_r;
  logic [MAG_W-1:0] s1_mb_r;
  logic             s1_ready, s2_ready, s3_ready;
  logic             s3_has_res, s3_go, out_free;

  logic                       goal_active_r;
  lane_ctl_t                  lane_ctl;
  logic [AXES-1:0][OUT_W-1:0] lane_val;
  logic [AXES-1:0]            lane_reach;
  logic                       reached;
  logic                       res_kind;
  logic [AXES-1:0][OUT_W-1:0] res_val;

  logic                       out_valid_r;
  logic                       out_kind_r;
  logic [AXES-1:0][OUT_W-1:0] out_val_r;

  assign in_vel = {in_ang_z, in_ang_y, in_ang_x, in_lin_z, in_lin_y, in_lin_x};

  // Advance each stage when the next one is free or moving
  assign out_free   = !out_valid_r || !out_stall;
  assign s3_has_res = (s3_ctl_r.kind == K_QUERY) || (s3_ctl_r.kind == K_TICK);
  assign s3_go      = s3_valid_r && (!s3_has_res || out_free);
  assign s3_ready   = !s3_valid_r || s3_go;
  assign s2_ready   = !s2_valid_r || s3_ready;
  assign s1_ready   = !s1_valid_r || s2_ready;
  assign in_stall   = !s1_ready;
  assign accept     = in_valid && s1_ready;

  vgs_front #(
    .VELOCITY_BITS (VELOCITY_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .opcode         (in_opcode),
    .vel            (in_vel),
    .goal_duration  (in_goal_duration),
    .integrate_flag (in_integrate_flag),
    .velocity_mode  (in_velocity_mode),
    .now_time       (in_now_time),
    .push           (push),
    .ctl            (front_ctl),
    .mb             (front_mb),
    .neg_b          (front_neg_b),
    .lane_a         (lane_a)
  );

  // Carry request control alongside the lane pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= accept && push;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_ctl_r <= front_ctl;
      s1_mb_r  <= front_mb;
    end
    if (s2_ready) begin
      s2_ctl_r <= s1_ctl_r;
    end
    if (s3_ready) begin
      s3_ctl_r <= s2_ctl_r;
    end
  end

  assign lane_ctl = '{
    s1_ld:  s1_ready,
    s2_ld:  s2_ready,
    s3_ld:  s3_ready,
    retire: s3_go,
    kind:   s3_ctl_r.kind,
    integ:  s3_ctl_r.integ,
    active: goal_active_r
  };

  // Six axis lanes side by side
  for (genvar g = 0; g < AXES; g++) begin : g_lane
    vgs_lane #(
      .VELOCITY_BITS (VELOCITY_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lane_ctl),
      .a_in     (lane_a[g]),
      .neg_b_in (front_neg_b),
      .s1_mb    (s1_mb_r),
      .value    (lane_val[g]),
      .reach    (lane_reach[g])
    );
  end

  vgs_merge u_merge (
    .kind         (s3_ctl_r.kind),
    .active       (goal_active_r),
    .integ        (s3_ctl_r.integ),
    .time_reached (s3_ctl_r.time_reached),
    .reach        (lane_reach),
    .lane_val     (lane_val),
    .reached      (reached),
    .res_kind     (res_kind),
    .res_val      (res_val)
  );

  // Track whether a goal is in progress, in request order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_active_r <= 1'b0;
    end else if (s3_go) begin
      case (s3_ctl_r.kind)
        K_GOAL:  goal_active_r <= 1'b1;
        K_MODE:  goal_active_r <= 1'b0;
        K_TICK:  goal_active_r <= goal_active_r && !reached;
        default: goal_active_r <= goal_active_r;
      endcase
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_go && s3_has_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go && s3_has_res) begin
      out_kind_r <= res_kind;
      out_val_r  <= res_val;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_lin_x       = out_val_r[0];
  assign out_lin_y       = out_val_r[1];
  assign out_lin_z       = out_val_r[2];
  assign out_ang_x       = out_val_r[3];
  assign out_ang_y       = out_val_r[4];
  assign out_ang_z       = out_val_r[5];

  // Stall only when the first stage is occupied and cannot move
  a_stall_needs_occupancy : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty first stage");

  // A retiring result always lands in the output register
  a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
    (s3_go && s3_has_res) |=> out_valid_r)
    else $error("retired result not presented");

  // A retiring goal request starts a goal
  a_goal_starts : assert property (@(posedge clk) disable iff (!rst_n)
    (s3_go && s3_ctl_r.kind == K_GOAL) |=> goal_active_r)
    else $error("goal request did not activate the goal");

  // A blocked last stage keeps its request
  a_last_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && !s3_go) |=> (s3_valid_r && $stable(s3_ctl_r)))
    else $error("blocked request lost from last stage");

endmodule

`default_nettype wire
